/* hw/rtl/portion_dispense_sequencer_macros.svh */
// Assertion macros used by the checker file of the dispense sequencer.
`ifndef PORTION_DISPENSE_SEQUENCER_MACROS_SVH
`define PORTION_DISPENSE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pds check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define PDS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pds check failed: next-cycle rule");

`endif

/* hw/rtl/pds_pkg.sv */
// Types, codes and constants of the portion dispense sequencer.
package pds_pkg;

  localparam int TICK_BITS_DEF = 16;
  localparam int DELAY_W       = 16;
  localparam int CFG_IDX_W     = 3;

  // Operation codes of an input word
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PORTION_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_TICKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_STOP_EN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_STOP_TICKS = 3'd6;

  // Register reset values
  localparam logic [7:0]  RST_DETECT_TICKS   = 8'd5;
  localparam logic [15:0] RST_MOTOR_TIMEOUT  = 16'd500;
  localparam logic [3:0]  RST_RETRY_LIMIT    = 4'd1;
  localparam logic [15:0] RST_PORTION_DELAY  = 16'd50;
  localparam logic [15:0] RST_REVERSE_TICKS  = 16'd50;
  localparam logic        RST_REV_STOP_EN    = 1'b0;
  localparam logic [15:0] RST_REV_STOP_TICKS = 16'd50;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_READY   = 3'd1,
    PH_LEAVE   = 3'd2,
    PH_WAITDET = 3'd3,
    PH_REV     = 3'd4,
    PH_REVSTOP = 3'd5,
    PH_OVER    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_PULL = 2'd1,
    DRV_PUSH = 2'd2
  } drive_t;

  typedef struct packed {
    logic       op;
    logic [7:0] portions;
    logic       position_sensor;
    logic       overcurrent;
  } req_t;

  typedef struct packed {
    logic [1:0] motor_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] delivered;
    logic       error_code;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DELAY_W-1:0]   value;
  } cfg_word_t;

  typedef struct packed {
    logic [7:0]         detect_ticks;
    logic [DELAY_W-1:0] motor_timeout_ticks;
    logic [3:0]         retry_limit;
    logic [DELAY_W-1:0] portion_delay_ticks;
    logic [DELAY_W-1:0] reverse_ticks;
    logic               reverse_stop_enable;
    logic [DELAY_W-1:0] reverse_stop_ticks;
  } cfg_regs_t;

  // Wait reload for a step delay: a delay of 0 behaves as 1.
  function automatic logic [DELAY_W-1:0] delay_reload(input logic [DELAY_W-1:0] d);
    delay_reload = (d == '0) ? '0 : d - 1'b1;
  endfunction

endpackage

/* hw/rtl/pds_if.sv */
// Valid/ready channel interfaces of the dispense sequencer.
interface pds_req_if;
  import pds_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pds_rsp_if;
  import pds_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pds_cfg_if;
  import pds_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pds_cfg.sv */
// Configuration register file of the dispense sequencer.
module pds_cfg (
  input  logic               clk,
  input  logic               rst,
  pds_cfg_if.sink            cfg,
  output pds_pkg::cfg_regs_t regs
);
  import pds_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.detect_ticks        <= RST_DETECT_TICKS;
      regs.motor_timeout_ticks <= RST_MOTOR_TIMEOUT;
      regs.retry_limit         <= RST_RETRY_LIMIT;
      regs.portion_delay_ticks <= RST_PORTION_DELAY;
      regs.reverse_ticks       <= RST_REVERSE_TICKS;
      regs.reverse_stop_enable <= RST_REV_STOP_EN;
      regs.reverse_stop_ticks  <= RST_REV_STOP_TICKS;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_DETECT_TICKS:   regs.detect_ticks        <= cfg.data.value[7:0];
        CFG_MOTOR_TIMEOUT:  regs.motor_timeout_ticks <= cfg.data.value;
        CFG_RETRY_LIMIT:    regs.retry_limit         <= cfg.data.value[3:0];
        CFG_PORTION_DELAY:  regs.portion_delay_ticks <= cfg.data.value;
        CFG_REVERSE_TICKS:  regs.reverse_ticks       <= cfg.data.value;
        CFG_REV_STOP_EN:    regs.reverse_stop_enable <= cfg.data.value[0];
        CFG_REV_STOP_TICKS: regs.reverse_stop_ticks  <= cfg.data.value;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/pds_core.sv */
// Input register and one-pass sequencer state update of the dispense sequencer.
module pds_core #(
  parameter int TICK_BITS = pds_pkg::TICK_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  pds_req_if.sink            req,
  input  pds_pkg::cfg_regs_t regs,
  input  logic               push_ok,
  output logic               push,
  output pds_pkg::rsp_t      push_data
);
  import pds_pkg::*;

  localparam int WAIT_W = (TICK_BITS > DELAY_W) ? TICK_BITS : DELAY_W;

  // input register
  logic s1_valid;
  req_t s1_word;
  logic adv;

  // sequencer state
  phase_t                phase, phase_next;
  logic [7:0]            portions_left, portions_left_next;
  logic [7:0]            portions_requested, portions_requested_next;
  logic [7:0]            hit_count, hit_count_next;
  logic [TICK_BITS-1:0]  timeout_left, timeout_left_next;
  logic [3:0]            retries_used, retries_used_next;
  logic [WAIT_W-1:0]     wait_left, wait_left_next;
  logic                  fault, fault_next;
  drive_t                drive_state, drive_state_next;

  logic                  done, err;
  logic [7:0]            deliv;
  logic [7:0]            hit_inc;
  logic [TICK_BITS-1:0]  tmo_load, tmo_base, tmo_dec;
  logic                  hit_seen, confirmed, run_check;

  assign adv       = s1_valid && push_ok;
  assign req.ready = !s1_valid || push_ok;
  assign push      = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_word <= req.data;
    end
  end

  assign hit_inc  = hit_count + 8'd1;
  assign tmo_load = TICK_BITS'(regs.motor_timeout_ticks);

  always_comb begin
    phase_next              = phase;
    portions_left_next      = portions_left;
    portions_requested_next = portions_requested;
    hit_count_next          = hit_count;
    timeout_left_next       = timeout_left;
    retries_used_next       = retries_used;
    wait_left_next          = wait_left;
    fault_next              = fault;
    drive_state_next        = drive_state;
    done                    = 1'b0;
    deliv                   = '0;
    err                     = 1'b0;
    hit_seen                = 1'b0;
    confirmed               = 1'b0;
    run_check               = 1'b0;
    tmo_base                = timeout_left;

    if (phase == PH_IDLE) begin
      if (s1_word.op == OP_START) begin
        portions_left_next      = s1_word.portions;
        portions_requested_next = s1_word.portions;
        hit_count_next          = '0;
        retries_used_next       = '0;
        fault_next              = 1'b0;
        drive_state_next        = DRV_STOP;
        wait_left_next          = '0;
        phase_next              = PH_READY;
      end
    end else if (wait_left != '0) begin
      wait_left_next = wait_left - 1'b1;
    end else begin
      case (phase)
        PH_READY: begin
          if (portions_left != '0) begin
            hit_count_next    = '0;
            timeout_left_next = tmo_load;
            drive_state_next  = DRV_PULL;
            phase_next        = PH_LEAVE;
          end else begin
            drive_state_next = DRV_STOP;
            phase_next       = PH_OVER;
            fault_next       = 1'b0;
          end
          wait_left_next = '0;
        end
        PH_LEAVE: begin
          hit_seen  = s1_word.position_sensor;
          confirmed = hit_seen && (hit_inc >= regs.detect_ticks);
          if (hit_seen) begin
            hit_count_next = confirmed ? 8'd0 : hit_inc;
          end
          if (confirmed) begin
            tmo_base   = tmo_load;
            phase_next = PH_WAITDET;
          end
          // timeout check still runs on the confirm tick
          run_check = 1'b1;
        end
        PH_WAITDET: begin
          hit_seen  = !s1_word.position_sensor;
          confirmed = hit_seen && (hit_inc >= regs.detect_ticks);
          if (confirmed) begin
            hit_count_next    = '0;
            fault_next        = 1'b0;
            if (portions_left != '0) begin
              portions_left_next = portions_left - 8'd1;
            end
            retries_used_next = '0;
            phase_next        = PH_READY;
            wait_left_next    = WAIT_W'(delay_reload(regs.portion_delay_ticks));
          end else begin
            if (hit_seen) begin
              hit_count_next = hit_inc;
            end
            run_check = 1'b1;
          end
        end
        PH_REV: begin
          drive_state_next = DRV_PUSH;
          phase_next       = regs.reverse_stop_enable ? PH_REVSTOP : PH_READY;
          wait_left_next   = WAIT_W'(delay_reload(regs.reverse_ticks));
        end
        PH_REVSTOP: begin
          drive_state_next = DRV_STOP;
          phase_next       = PH_READY;
          wait_left_next   = WAIT_W'(delay_reload(regs.reverse_stop_ticks));
        end
        default: begin
          // run over, and any unused phase code
          done              = 1'b1;
          deliv             = portions_requested - portions_left;
          err               = fault;
          drive_state_next  = DRV_STOP;
          retries_used_next = '0;
          wait_left_next    = '0;
          phase_next        = PH_IDLE;
        end
      endcase
    end

    tmo_dec = tmo_base - 1'b1;
    if (run_check) begin
      timeout_left_next = tmo_dec;
      wait_left_next    = '0;
      if (tmo_dec == '0 || s1_word.overcurrent) begin
        if (retries_used < regs.retry_limit) begin
          retries_used_next = retries_used + 4'd1;
          phase_next        = PH_REV;
        end else begin
          fault_next       = 1'b1;
          drive_state_next = DRV_STOP;
          phase_next       = PH_OVER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      portions_left      <= '0;
      portions_requested <= '0;
      hit_count          <= '0;
      timeout_left       <= '0;
      retries_used       <= '0;
      wait_left          <= '0;
      fault              <= 1'b0;
      drive_state        <= DRV_STOP;
    end else if (adv) begin
      phase              <= phase_next;
      portions_left      <= portions_left_next;
      portions_requested <= portions_requested_next;
      hit_count          <= hit_count_next;
      timeout_left       <= timeout_left_next;
      retries_used       <= retries_used_next;
      wait_left          <= wait_left_next;
      fault              <= fault_next;
      drive_state        <= drive_state_next;
    end
  end

  always_comb begin
    push_data.motor_drive = drive_state_next;
    push_data.busy_res    = (phase_next != PH_IDLE);
    push_data.done_res    = done;
    push_data.delivered   = deliv;
    push_data.error_code  = err;
  end

endmodule

/* hw/rtl/pds_outq.sv */
// Two-entry result queue that decouples the sequencer from the output side.
module pds_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pds_pkg::rsp_t push_data,
  output logic          push_ok,
  pds_rsp_if.source     rsp
);
  import pds_pkg::*;

  rsp_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign push_ok   = (count != 2'd2);
  assign rsp.valid = (count != 2'd0);
  assign rsp.data  = slots[rd_ptr];
  assign pop       = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* hw/rtl/portion_dispense_sequencer.sv */
// Top level of the portion dispense sequencer: config regs, sequencer core, result queue.
//
//   channel | dir  | word                                             | accepted when
//   --------+------+--------------------------------------------------+-------------------------
//   req     | in   | op, portions, position_sensor, overcurrent       | req.valid && req.ready
//   rsp     | out  | motor_drive, busy_res, done_res, delivered, err  | rsp.valid && rsp.ready
//   cfg     | in   | index (3b), value (16b)                          | cfg.valid && cfg.ready
//
// One word per cycle sustained while the rsp side keeps up; each req word yields exactly one rsp word.
// The req word lands in an input register, the sequencer
// state updates in one pass and the result is written to a two-entry queue.
// req.ready drops only when the input register holds a word and the queue is full.
// cfg.ready is always high; a write lands the next edge. rst is synchronous, active
// high, and clears the sequencer to idle with the motor stopped and registers at defaults.
module portion_dispense_sequencer #(
  parameter int TICK_BITS = pds_pkg::TICK_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  pds_req_if.sink    req,
  pds_rsp_if.source  rsp,
  pds_cfg_if.sink    cfg
);
  import pds_pkg::*;

  cfg_regs_t regs;
  logic      push;
  logic      push_ok;
  rsp_t      push_data;

  // register file, written any time; the user is to change it only while the sequencer is idle, not enforced here
  pds_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // input register plus single-pass state update: ticks, detection, retry, done
  pds_core #(
    .TICK_BITS (TICK_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .regs      (regs),
    .push_ok   (push_ok),
    .push      (push),
    .push_data (push_data)
  );

  // result words wait here so input keeps flowing while rsp is stalled, until the queue fills
  pds_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .push_ok   (push_ok),
    .rsp       (rsp)
  );

endmodule

/* hw/rtl/pds_checker.sv */
// Port-level checks of the dispense sequencer and their bind to the top level.
`include "portion_dispense_sequencer_macros.svh"

module pds_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input pds_pkg::rsp_t rsp_data
);
  import pds_pkg::*;

  // no result shows on the first edge after reset
  `PDS_ASSERT_IMP(a_quiet_after_rst, clk, rst, $past(rst), !rsp_valid)

  // a finishing word ends the run with the motor stopped
  `PDS_ASSERT_IMP(a_done_stops, clk, rst, rsp_valid && rsp_data.done_res, !rsp_data.busy_res && rsp_data.motor_drive == DRV_STOP)

  // count and error are reported only with done
  `PDS_ASSERT_IMP(a_report_with_done, clk, rst, rsp_valid && !rsp_data.done_res, rsp_data.delivered == 8'd0 && !rsp_data.error_code)

  // a stalled result word holds
  `PDS_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind portion_dispense_sequencer pds_checker u_pds_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
